[design/first_fit_heap_allocator_assert.svh]
// ---------------------------------------------------------------------------
// first_fit_heap_allocator assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("first_fit_heap_allocator check failed");

// Next-cycle implication.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("first_fit_heap_allocator check failed");

`endif

[design/ffha_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_pkg
// Item types, status codes and controller/datapath command types.
// ---------------------------------------------------------------------------
package ffha_pkg;

   typedef struct packed {
      logic        kind;
      logic [15:0] req_bytes;
      logic [13:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [13:0] payload_offset;
      logic [1:0]  status;
      logic [14:0] free_total;
      logic [14:0] used_total;
   } rsp_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ZERO    = 2'd1;
   localparam logic [1:0] ST_NOMEM   = 2'd2;
   localparam logic [1:0] ST_BADFREE = 2'd3;

   localparam int REQ_BYTES_W = 16;

   // Datapath operations.
   localparam logic [4:0] OP_NONE     = 5'd0;
   localparam logic [4:0] OP_INIT     = 5'd1;
   localparam logic [4:0] OP_ACCEPT   = 5'd2;
   localparam logic [4:0] OP_ROUND_Q  = 5'd3;
   localparam logic [4:0] OP_ROUND_W  = 5'd4;
   localparam logic [4:0] OP_SCAN_RD  = 5'd5;
   localparam logic [4:0] OP_SCAN_CHK = 5'd6;
   localparam logic [4:0] OP_TAKE     = 5'd7;
   localparam logic [4:0] OP_INS_RD   = 5'd8;
   localparam logic [4:0] OP_INS_WR   = 5'd9;
   localparam logic [4:0] OP_INS_FIN  = 5'd10;
   localparam logic [4:0] OP_NEXT_RD  = 5'd11;
   localparam logic [4:0] OP_NEXT_CHK = 5'd12;
   localparam logic [4:0] OP_REM_RD   = 5'd13;
   localparam logic [4:0] OP_REM_WR   = 5'd14;
   localparam logic [4:0] OP_REM_FIN  = 5'd15;
   localparam logic [4:0] OP_PREV_RD  = 5'd16;
   localparam logic [4:0] OP_PREV_CHK = 5'd17;
   localparam logic [4:0] OP_WR_CUR   = 5'd18;
   localparam logic [4:0] OP_FIN      = 5'd19;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] status;
   } ffha_cmd_type;

   typedef struct packed {
      logic req_free;
      logic req_zero;
      logic req_null;
      logic hit;
      logic last;
      logic rd_free;
      logic split_ok;
      logic next_exists;
      logic prev_exists;
      logic ins_more;
      logic rem_more;
      logic rsp_busy;
   } ffha_flag_type;

endpackage

[design/ffha_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/ffha_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the allocate and free flows of the block table.
// ---------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ffha_flag_type flags,
   output ffha_cmd_type  cmd
);

   localparam logic [4:0] S_INIT     = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ROUND_Q  = 5'd2;
   localparam logic [4:0] S_ROUND_W  = 5'd3;
   localparam logic [4:0] S_SCAN_RD  = 5'd4;
   localparam logic [4:0] S_SCAN_CHK = 5'd5;
   localparam logic [4:0] S_TAKE     = 5'd6;
   localparam logic [4:0] S_INS_CHK  = 5'd7;
   localparam logic [4:0] S_INS_RD   = 5'd8;
   localparam logic [4:0] S_INS_WR   = 5'd9;
   localparam logic [4:0] S_INS_FIN  = 5'd10;
   localparam logic [4:0] S_NEXT_RD  = 5'd11;
   localparam logic [4:0] S_NEXT_CHK = 5'd12;
   localparam logic [4:0] S_REM_CHK  = 5'd13;
   localparam logic [4:0] S_REM_RD   = 5'd14;
   localparam logic [4:0] S_REM_WR   = 5'd15;
   localparam logic [4:0] S_REM_FIN  = 5'd16;
   localparam logic [4:0] S_PREV_RD  = 5'd17;
   localparam logic [4:0] S_PREV_CHK = 5'd18;
   localparam logic [4:0] S_WR_CUR   = 5'd19;
   localparam logic [4:0] S_FIN      = 5'd20;

   localparam logic RET_PREV = 1'b0;
   localparam logic RET_FIN  = 1'b1;

   logic [4:0] state_ff, state_in;
   logic [1:0] st_ff, st_in;
   logic       ret_ff, ret_in;
   logic       kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      st_in     = st_ff;
      ret_in    = ret_ff;
      kind_in   = kind_ff;
      cmd.op    = OP_NONE;
      cmd.status = st_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = OP_ACCEPT;
               kind_in = flags.req_free;
               st_in   = ST_OK;
               if (flags.req_free) begin
                  state_in = flags.req_null ? S_FIN : S_SCAN_RD;
               end else if (flags.req_zero) begin
                  st_in    = ST_ZERO;
                  state_in = S_FIN;
               end else begin
                  state_in = S_ROUND_Q;
               end
            end
         end
         S_ROUND_Q: begin
            cmd.op   = OP_ROUND_Q;
            state_in = S_ROUND_W;
         end
         S_ROUND_W: begin
            cmd.op   = OP_ROUND_W;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.op = OP_SCAN_CHK;
            if (flags.hit) begin
               if (kind_ff == KIND_ALLOC) begin
                  state_in = S_TAKE;
               end else if (flags.rd_free) begin
                  st_in    = ST_BADFREE;
                  state_in = S_FIN;
               end else begin
                  state_in = S_NEXT_RD;
               end
            end else if (flags.last) begin
               st_in    = (kind_ff == KIND_ALLOC) ? ST_NOMEM : ST_BADFREE;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_TAKE: begin
            cmd.op   = OP_TAKE;
            state_in = flags.split_ok ? S_INS_CHK : S_FIN;
         end
         S_INS_CHK: begin
            state_in = flags.ins_more ? S_INS_RD : S_INS_FIN;
         end
         S_INS_RD: begin
            cmd.op   = OP_INS_RD;
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.op   = OP_INS_WR;
            state_in = S_INS_CHK;
         end
         S_INS_FIN: begin
            cmd.op   = OP_INS_FIN;
            state_in = S_FIN;
         end
         S_NEXT_RD: begin
            cmd.op   = OP_NEXT_RD;
            state_in = flags.next_exists ? S_NEXT_CHK : S_PREV_RD;
         end
         S_NEXT_CHK: begin
            cmd.op = OP_NEXT_CHK;
            if (flags.rd_free) begin
               ret_in   = RET_PREV;
               state_in = S_REM_CHK;
            end else begin
               state_in = S_PREV_RD;
            end
         end
         S_REM_CHK: begin
            state_in = flags.rem_more ? S_REM_RD : S_REM_FIN;
         end
         S_REM_RD: begin
            cmd.op   = OP_REM_RD;
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            cmd.op   = OP_REM_WR;
            state_in = S_REM_CHK;
         end
         S_REM_FIN: begin
            cmd.op   = OP_REM_FIN;
            state_in = (ret_ff == RET_PREV) ? S_PREV_RD : S_FIN;
         end
         S_PREV_RD: begin
            cmd.op   = OP_PREV_RD;
            state_in = flags.prev_exists ? S_PREV_CHK : S_WR_CUR;
         end
         S_PREV_CHK: begin
            cmd.op = OP_PREV_CHK;
            if (flags.rd_free) begin
               ret_in   = RET_FIN;
               state_in = S_REM_CHK;
            end else begin
               state_in = S_WR_CUR;
            end
         end
         S_WR_CUR: begin
            cmd.op   = OP_WR_CUR;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!flags.rsp_busy) begin
               cmd.op   = OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         st_ff    <= ST_OK;
         ret_ff   <= RET_PREV;
         kind_ff  <= KIND_ALLOC;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
         ret_ff   <= ret_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

[design/ffha_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_datapath
// Block table memory, scan pointer, working entry, byte totals, result register.
// ---------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = 16384,
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 40,
   parameter int ALIGN_BYTES  = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  ffha_cmd_type  cmd,
   output ffha_flag_type flags
);

   localparam int HW  = $clog2(ARENA_BYTES);
   localparam int SW  = $clog2(ARENA_BYTES + 1);
   localparam int IW  = $clog2(MAX_BLOCKS);
   localparam int NW  = $clog2(MAX_BLOCKS + 1);
   localparam int EW  = HW + SW + 1;
   localparam int WW  = REQ_BYTES_W + 1;
   localparam int CW  = ((SW > WW) ? SW : WW) + 2;
   localparam int AB  = $clog2(ALIGN_BYTES);
   localparam int AW  = $clog2(ALIGN_BYTES + 1);
   localparam int RS  = WW + AB;
   localparam int RMW = RS + 1;
   localparam logic [RMW-1:0] RECIP = RMW'((2 ** RS + ALIGN_BYTES - 1) / ALIGN_BYTES);

   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] ptr_ff, ptr_in;
   logic [IW-1:0] hit_ff, hit_in;
   logic          kind_ff, kind_in;
   logic [REQ_BYTES_W-1:0] req_bytes_ff, req_bytes_in;
   logic [13:0]   off_ff, off_in;
   logic [WW-1:0] q_ff, q_in;
   logic [WW-1:0] wanted_ff, wanted_in;
   logic [HW-1:0] cur_hdr_ff, cur_hdr_in;
   logic [SW-1:0] cur_size_ff, cur_size_in;
   logic [SW-1:0] free_tot_ff, free_tot_in;
   logic [SW-1:0] used_tot_ff, used_tot_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [HW-1:0] rd_hdr;
   logic [SW-1:0] rd_size;
   logic          rd_free;

   logic [WW-1:0]     round_x;
   logic [WW+RMW-1:0] round_prod;
   logic [WW+AW-1:0]  wanted_prod;
   logic              fit, match_off;
   logic [NW-1:0]     hit_p1;
   logic [SW-1:0]     wanted_s;

   ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_hdr  = ram_rdata[EW-1 -: HW];
   assign rd_size = ram_rdata[SW:1];
   assign rd_free = ram_rdata[0];

   // Round-up to the alignment: multiply by a scaled reciprocal, then back.
   assign round_x     = WW'(req_bytes_ff) + WW'(ALIGN_BYTES - 1);
   assign round_prod  = (WW + RMW)'(round_x) * (WW + RMW)'(RECIP);
   assign wanted_prod = (WW + AW)'(q_ff) * (WW + AW)'(ALIGN_BYTES);
   assign wanted_s    = SW'(wanted_ff);

   assign fit       = rd_free && (CW'(rd_size) >= CW'(wanted_ff));
   assign match_off = (CW'(rd_hdr) + CW'(HEADER_BYTES)) == CW'(off_ff);
   assign hit_p1    = NW'(hit_ff) + NW'(1);

   always_comb begin
      flags.req_free    = req_data.kind;
      flags.req_zero    = (req_data.req_bytes == '0);
      flags.req_null    = (req_data.free_offset == '0);
      flags.hit         = kind_ff ? match_off : fit;
      flags.last        = (ptr_ff + NW'(1)) == count_ff;
      flags.rd_free     = rd_free;
      flags.split_ok    = (CW'(cur_size_ff) >= CW'(wanted_ff) + CW'(HEADER_BYTES)
                           + CW'(ALIGN_BYTES)) && (count_ff < NW'(MAX_BLOCKS));
      flags.next_exists = hit_p1 < count_ff;
      flags.prev_exists = (hit_ff != '0);
      flags.ins_more    = ptr_ff > hit_p1;
      flags.rem_more    = (ptr_ff + NW'(1)) < count_ff;
      flags.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      hit_in       = hit_ff;
      kind_in      = kind_ff;
      req_bytes_in = req_bytes_ff;
      off_in       = off_ff;
      q_in         = q_ff;
      wanted_in    = wanted_ff;
      cur_hdr_in   = cur_hdr_ff;
      cur_size_in  = cur_size_ff;
      free_tot_in  = free_tot_ff;
      used_tot_in  = used_tot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = hit_ff;
      ram_wdata    = {cur_hdr_ff, cur_size_ff, 1'b1};
      ram_raddr    = ptr_ff[IW-1:0];
      case (cmd.op)
         OP_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {HW'(0), SW'(ARENA_BYTES - HEADER_BYTES), 1'b1};
         end
         OP_ACCEPT: begin
            kind_in      = req_data.kind;
            req_bytes_in = req_data.req_bytes;
            off_in       = req_data.free_offset;
            ptr_in       = '0;
         end
         OP_ROUND_Q: begin
            q_in = round_prod[RS +: WW];
         end
         OP_ROUND_W: begin
            wanted_in = wanted_prod[WW-1:0];
         end
         OP_SCAN_RD: begin
            ram_raddr = ptr_ff[IW-1:0];
         end
         OP_SCAN_CHK: begin
            if (flags.hit) begin
               hit_in      = ptr_ff[IW-1:0];
               cur_hdr_in  = rd_hdr;
               cur_size_in = rd_size;
            end else begin
               ptr_in = ptr_ff + NW'(1);
            end
         end
         OP_TAKE: begin
            ram_we = 1'b1;
            if (flags.split_ok) begin
               ram_wdata   = {cur_hdr_ff, wanted_s, 1'b0};
               free_tot_in = free_tot_ff - wanted_s - SW'(HEADER_BYTES);
               used_tot_in = used_tot_ff + wanted_s;
               ptr_in      = count_ff;
            end else begin
               ram_wdata   = {cur_hdr_ff, cur_size_ff, 1'b0};
               free_tot_in = free_tot_ff - cur_size_ff;
               used_tot_in = used_tot_ff + cur_size_ff;
            end
         end
         OP_INS_RD: begin
            ram_raddr = IW'(ptr_ff - NW'(1));
         end
         OP_INS_WR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[IW-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff - NW'(1);
         end
         OP_INS_FIN: begin
            ram_we    = 1'b1;
            ram_waddr = hit_p1[IW-1:0];
            ram_wdata = {HW'(cur_hdr_ff + HW'(HEADER_BYTES) + HW'(wanted_ff)),
                         SW'(cur_size_ff - wanted_s - SW'(HEADER_BYTES)), 1'b1};
            count_in  = count_ff + NW'(1);
         end
         OP_NEXT_RD: begin
            ram_raddr   = hit_p1[IW-1:0];
            free_tot_in = free_tot_ff + cur_size_ff;
            used_tot_in = used_tot_ff - cur_size_ff;
         end
         OP_NEXT_CHK: begin
            if (rd_free) begin
               cur_size_in = cur_size_ff + SW'(HEADER_BYTES) + rd_size;
               free_tot_in = free_tot_ff + SW'(HEADER_BYTES);
               ptr_in      = hit_p1;
            end
         end
         OP_REM_RD: begin
            ram_raddr = IW'(ptr_ff + NW'(1));
         end
         OP_REM_WR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff[IW-1:0];
            ram_wdata = ram_rdata;
            ptr_in    = ptr_ff + NW'(1);
         end
         OP_REM_FIN: begin
            count_in = count_ff - NW'(1);
         end
         OP_PREV_RD: begin
            ram_raddr = hit_ff - IW'(1);
         end
         OP_PREV_CHK: begin
            if (rd_free) begin
               ram_we      = 1'b1;
               ram_waddr   = hit_ff - IW'(1);
               ram_wdata   = {rd_hdr, SW'(rd_size + SW'(HEADER_BYTES) + cur_size_ff), 1'b1};
               free_tot_in = free_tot_ff + SW'(HEADER_BYTES);
               ptr_in      = NW'(hit_ff);
            end
         end
         OP_WR_CUR: begin
            ram_we    = 1'b1;
            ram_waddr = hit_ff;
            ram_wdata = {cur_hdr_ff, cur_size_ff, 1'b1};
         end
         OP_FIN: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = cmd.status;
            rsp_in.free_total = 15'(free_tot_ff);
            rsp_in.used_total = 15'(used_tot_ff);
            if ((cmd.status == ST_OK) && (kind_ff == KIND_ALLOC)) begin
               rsp_in.payload_offset = 14'(cur_hdr_ff + HW'(HEADER_BYTES));
            end else begin
               rsp_in.payload_offset = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= NW'(1);
         ptr_ff       <= '0;
         free_tot_ff  <= SW'(ARENA_BYTES - HEADER_BYTES);
         used_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         free_tot_ff  <= free_tot_in;
         used_tot_ff  <= used_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      kind_ff      <= kind_in;
      req_bytes_ff <= req_bytes_in;
      off_ff       <= off_in;
      q_ff         <= q_in;
      wanted_ff    <= wanted_in;
      cur_hdr_ff   <= cur_hdr_in;
      cur_size_ff  <= cur_size_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed arena with block split and free coalescing.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Ports                          Carries
//   request   in         req_valid req_ready req_data   allocate or free item
//   response  out        rsp_valid rsp_ready rsp_data   offset, status, totals
//
// A zero-size allocate or a null free goes straight to the response. An
// allocate rounds its size up to the alignment and scans the table entry by
// entry; it fails with no memory after the last entry, or takes the first
// block that fits and, on a split, moves later entries up to insert the rest.
// A free scans for its block and is bad if none matches or the block is free;
// a valid free merges with a free next block, moving later entries down, then
// with a free previous block, again moving entries down. The block table has
// a single read port. After reset, the init state writes the initial free
// block before the first item is taken. A stalled response holds in the
// output register while the next item is already accepted and worked on;
// that item then waits in its last step until the register frees.
//
// The block table is kept address ordered in a RAM; the controller walks it
// one entry at a time, and shifts entries when a split inserts a block or a
// merge removes one. Free and used byte totals are kept as running sums, so
// every response reports them without a walk.
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int ARENA_BYTES  = 16384,
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 40,
   parameter int ALIGN_BYTES  = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ffha_cmd_type  cmd;
   ffha_flag_type flags;

   // The controller sequences each item; the datapath holds all table state.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   ffha_datapath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .flags     (flags)
   );

endmodule

[design/ffha_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker import ffha_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic offset_set;

   assign offset_set = rsp_valid && (rsp_data.payload_offset != '0);

   `FFHA_ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `FFHA_ASSERT_NEXT(rsp_data_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `FFHA_ASSERT_NOW(offset_only_on_ok, clock, reset, offset_set, rsp_data.status == ST_OK)
   `FFHA_ASSERT_NEXT(one_item_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
